>>> sv/abkf_pkg.sv
package abkf_pkg;

    // Default estimate width and fixed field widths.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_W          = 32;
    localparam int ADDR_W         = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    // Register reset values, unsigned Q0.32.
    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 32'd4294967;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 32'd12884902;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 32'd128849019;
    localparam logic [CFG_W-1:0] PERIOD_RST      = 32'd42949673;

    // One in Q2.30.
    localparam logic signed [31:0] COV_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [24:0] accel_angle;
        logic signed [27:0] gyro_dps;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] unbiased_rate;
        logic signed [31:0] bias_estimate;
    } t_out_item;

endpackage

>>> sv/angle_bias_kalman_filter.sv
// Two-state Kalman filter for a tilt angle and the gyro bias.
// Input channel: i_in_valid / o_in_stall carry one transaction holding the
// accelerometer angle and gyro rate (signed Q9.16, Q12.16). Output channel:
// o_out_valid / i_out_stall carry one transaction per input with the
// filtered angle, unbiased rate and bias estimate, saturated to 32 bits.
// The APB port sets the noise terms and the sample period; write it only
// while the filter is idle. pready is always high.
// Each sample is computed by one shared shift-add multiplier (ten products)
// and one restoring divider (two gains); when the innovation variance is
// not positive the divider is skipped and the gains are zero.
// The input stalls for the whole computation; the next sample is taken
// once the result is in the output register and the filter is idle again.
// A stall on the output holds the result; the filter still accepts and
// computes the next sample, and waits at its end until the output frees.
// Reset loads the default register values, clears the estimates and sets
// the covariance to the identity.
module angle_bias_kalman_filter #(
    parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  abkf_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output abkf_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abkf_pkg::ADDR_W-1:0]   paddr,
    input  logic [abkf_pkg::CFG_W-1:0]    pwdata,
    output logic [abkf_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);
    import abkf_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int AW = (DW > 34) ? DW : 34;
    localparam int BW = 33;
    localparam int PW = AW + BW;
    localparam int XW = PW + 2;

    localparam logic signed [XW-1:0] DMAX = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [XW-1:0] DMIN = ~DMAX;
    localparam logic signed [XW-1:0] WMAX = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] WMIN = ~WMAX;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_ANG, S_P11, S_PAA, S_PBB, S_K0,
        S_K1, S_CA, S_CB, S_CC, S_CD, S_CE, S_CF, S_CG
    } t_state;

    function automatic logic signed [DW-1:0] sat_d(input logic signed [XW-1:0] x);
        if (x > DMAX) return DMAX[DW-1:0];
        else if (x < DMIN) return DMIN[DW-1:0];
        else return x[DW-1:0];
    endfunction

    function automatic logic signed [31:0] sat_w(input logic signed [XW-1:0] x);
        if (x > WMAX) return WMAX[31:0];
        else if (x < WMIN) return WMIN[31:0];
        else return x[31:0];
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_apn, r_bpn, r_rn, r_dt;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= ANGLE_NOISE_RST;
            r_bpn <= BIAS_NOISE_RST;
            r_rn  <= MEAS_NOISE_RST;
            r_dt  <= PERIOD_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ANGLE_NOISE: r_apn <= pwdata;
                REG_BIAS_NOISE:  r_bpn <= pwdata;
                REG_MEAS_NOISE:  r_rn  <= pwdata;
                REG_PERIOD:      r_dt  <= pwdata;
                default:         r_apn <= r_apn;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_ANGLE_NOISE: prdata = r_apn;
            REG_BIAS_NOISE:  prdata = r_bpn;
            REG_MEAS_NOISE:  prdata = r_rn;
            REG_PERIOD:      prdata = r_dt;
            default:         prdata = r_apn;
        endcase
    end

    // Sequencer, filter state and the shared multiplier and divider.
    t_state                  r_state, n_state, r_ret, n_ret;
    logic signed [DW-1:0]    r_angle, n_angle, r_bias, n_bias, r_rate, n_rate;
    logic signed [DW-1:0]    r_y, n_y;
    logic signed [24:0]      r_meas, n_meas;
    logic signed [31:0]      r_caa, n_caa, r_cab, n_cab, r_cba, n_cba, r_cbb, n_cbb;
    logic signed [31:0]      r_k0, n_k0, r_k1, n_k1;
    logic signed [PW-1:0]    r_mc, n_mc, r_acc, n_acc;
    logic [BW-1:0]           r_mp, n_mp;
    logic [5:0]              r_mcnt, n_mcnt;
    logic [63:0]             r_dq, n_dq;
    logic [33:0]             r_rem, n_rem, r_den, n_den;
    logic [5:0]              r_dcnt, n_dcnt;
    logic                    r_dneg, n_dneg;
    logic                    r_ov, n_ov;
    t_out_item               r_out, n_out;

    logic                    mul_go, div_go;
    logic signed [XW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [31:0]      div_p;
    logic [31:0]             div_mag;
    t_state                  go_ret;
    logic signed [PW-1:0]    addend;
    logic signed [XW-1:0]    acc_x, sh30, sh32, sh34, inner, sx;
    logic [34:0]             rem2, diff;
    logic signed [31:0]      quot;

    assign acc_x = XW'(r_acc);
    assign sh30  = acc_x >>> 30;
    assign sh32  = acc_x >>> 32;
    assign sh34  = acc_x >>> 34;
    assign inner = sh32 - XW'(r_cab) - XW'(r_cba) + XW'($signed({1'b0, r_apn[31:2]}));
    assign sx    = (XW'(r_caa) <<< 2) + XW'($signed({1'b0, r_rn}));
    assign rem2  = {r_rem, r_dq[63]};
    assign diff  = rem2 - {1'b0, r_den};
    assign addend = r_mp[0] ? r_mc : '0;

    // Quotient magnitude to a saturated, signed gain.
    always_comb begin
        if (r_dneg) begin
            if (r_dq > 64'h8000_0000) quot = 32'sh8000_0000;
            else quot = 32'(-r_dq);
        end else begin
            if (r_dq > 64'h7FFF_FFFF) quot = 32'sh7FFF_FFFF;
            else quot = r_dq[31:0];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_angle = r_angle; n_bias = r_bias; n_rate = r_rate; n_y = r_y;
        n_meas = r_meas;
        n_caa = r_caa; n_cab = r_cab; n_cba = r_cba; n_cbb = r_cbb;
        n_k0 = r_k0; n_k1 = r_k1;
        n_mc = r_mc; n_mp = r_mp; n_acc = r_acc; n_mcnt = r_mcnt;
        n_dq = r_dq; n_rem = r_rem; n_den = r_den; n_dcnt = r_dcnt; n_dneg = r_dneg;
        n_ov = r_ov; n_out = r_out;
        mul_go = 1'b0; div_go = 1'b0; go_ret = S_IDLE;
        mul_a = '0; mul_b = '0; div_p = '0;

        if (r_ov && !i_out_stall) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_meas = i_in_data.accel_angle;
                    n_rate = sat_d(XW'(i_in_data.gyro_dps) - XW'(r_bias));
                    mul_a = XW'(n_rate); mul_b = $signed({1'b0, r_dt});
                    mul_go = 1'b1; go_ret = S_ANG;
                end
            end
            S_MUL: begin
                if (r_mcnt == 6'(BW - 1)) begin
                    n_acc = r_acc - addend;
                    n_state = r_ret;
                end else begin
                    n_acc = r_acc + addend;
                end
                n_mc = r_mc <<< 1;
                n_mp = r_mp >> 1;
                n_mcnt = r_mcnt + 6'd1;
            end
            S_DIV: begin
                if (!diff[34]) begin
                    n_rem = diff[33:0];
                    n_dq = {r_dq[62:0], 1'b1};
                end else begin
                    n_rem = rem2[33:0];
                    n_dq = {r_dq[62:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) n_state = r_ret;
            end
            // Predict: angle, then covariance.
            S_ANG: begin
                n_angle = sat_d(XW'(r_angle) + sh32);
                mul_a = XW'(r_cbb); mul_b = $signed({1'b0, r_dt});
                mul_go = 1'b1; go_ret = S_P11;
            end
            S_P11: begin
                n_cab = sat_w(XW'(r_cab) - sh32);
                n_cba = sat_w(XW'(r_cba) - sh32);
                mul_a = inner; mul_b = $signed({1'b0, r_dt});
                mul_go = 1'b1; go_ret = S_PAA;
            end
            S_PAA: begin
                n_caa = sat_w(XW'(r_caa) + sh32);
                mul_a = XW'($signed({1'b0, r_bpn})); mul_b = $signed({1'b0, r_dt});
                mul_go = 1'b1; go_ret = S_PBB;
            end
            // Innovation and gains.
            S_PBB: begin
                n_cbb = sat_w(XW'(r_cbb) + sh34);
                n_y = sat_d(XW'(r_meas) - XW'(r_angle));
                n_den = sx[33:0];
                if (!sx[XW-1] && (sx != '0)) begin
                    div_p = r_caa; div_go = 1'b1; go_ret = S_K0;
                end else begin
                    n_k0 = '0; n_k1 = '0; n_state = S_CA;
                end
            end
            S_K0: begin
                n_k0 = quot;
                div_p = r_cba; div_go = 1'b1; go_ret = S_K1;
            end
            S_K1: begin
                n_k1 = quot;
                n_state = S_CA;
            end
            // Correct estimates, then covariance.
            S_CA: begin
                mul_a = XW'(r_y); mul_b = BW'(r_k0);
                mul_go = 1'b1; go_ret = S_CB;
            end
            S_CB: begin
                n_angle = sat_d(XW'(r_angle) + sh30);
                mul_a = XW'(r_y); mul_b = BW'(r_k1);
                mul_go = 1'b1; go_ret = S_CC;
            end
            S_CC: begin
                n_bias = sat_d(XW'(r_bias) + sh30);
                mul_a = XW'(r_caa); mul_b = BW'(r_k1);
                mul_go = 1'b1; go_ret = S_CD;
            end
            S_CD: begin
                n_cba = sat_w(XW'(r_cba) - sh30);
                mul_a = XW'(r_cab); mul_b = BW'(r_k1);
                mul_go = 1'b1; go_ret = S_CE;
            end
            S_CE: begin
                n_cbb = sat_w(XW'(r_cbb) - sh30);
                mul_a = XW'(r_caa); mul_b = BW'(r_k0);
                mul_go = 1'b1; go_ret = S_CF;
            end
            S_CF: begin
                n_caa = sat_w(XW'(r_caa) - sh30);
                mul_a = XW'(r_cab); mul_b = BW'(r_k0);
                mul_go = 1'b1; go_ret = S_CG;
            end
            // Last covariance term and the result, once the output is free.
            S_CG: begin
                if (!r_ov || !i_out_stall) begin
                    n_cab = sat_w(XW'(r_cab) - sh30);
                    n_out.filtered_angle = sat_w(XW'(r_angle));
                    n_out.unbiased_rate  = sat_w(XW'(r_rate));
                    n_out.bias_estimate  = sat_w(XW'(r_bias));
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Start a product.
        if (mul_go) begin
            n_mc = PW'(mul_a);
            n_mp = mul_b;
            n_acc = '0;
            n_mcnt = '0;
            n_ret = go_ret;
            n_state = S_MUL;
        end

        // Start a gain division on the magnitude of the numerator.
        div_mag = div_p[31] ? 32'(-div_p) : div_p;
        if (div_go) begin
            n_dq = {div_mag, 32'd0};
            n_rem = '0;
            n_dcnt = '0;
            n_dneg = div_p[31];
            n_ret = go_ret;
            n_state = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_angle <= '0;
            r_bias  <= '0;
            r_rate  <= '0;
            r_caa   <= COV_ONE;
            r_cab   <= '0;
            r_cba   <= '0;
            r_cbb   <= COV_ONE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_angle <= n_angle;
            r_bias  <= n_bias;
            r_rate  <= n_rate;
            r_caa   <= n_caa;
            r_cab   <= n_cab;
            r_cba   <= n_cba;
            r_cbb   <= n_cbb;
            r_ov    <= n_ov;
        end
        r_y    <= n_y;
        r_meas <= n_meas;
        r_k0   <= n_k0;
        r_k1   <= n_k1;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_acc  <= n_acc;
        r_mcnt <= n_mcnt;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_dcnt <= n_dcnt;
        r_dneg <= n_dneg;
        r_out  <= n_out;
    end

endmodule

>>> tb/sv/abkf_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the filter, predicts
// every output transaction in fixed point and compares it field by field.
module abkf_checker
    import abkf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [CFG_W-1:0]  i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results
);

    // Shadow copy of the registers and the filter state.
    longint angle_noise, bias_noise, meas_noise, period;
    longint angle_est, bias_est, rate_est;
    longint cov_aa, cov_ab, cov_ba, cov_bb;
    t_out_item expected_q[$];

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_est(longint x);
        longint hi;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        return clamp_to(x, -hi - 1, hi);
    endfunction

    function automatic longint sat_word(longint x);
        return clamp_to(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // Exact product, floored by s bits; done at 128 bits to avoid overflow.
    function automatic longint fx_mul(longint a, longint b, int s);
        logic signed [127:0] p;
        p = $signed(128'(a)) * $signed(128'(b));
        p = p >>> s;
        return longint'(p);
    endfunction

    // Gain: (p * 2^32) / s truncated toward zero, then saturated.
    function automatic longint fx_gain(longint p, longint s);
        logic signed [127:0] n;
        n = $signed(128'(p)) <<< 32;
        n = n / $signed(128'(s));
        if (n > 128'sd2147483647) return 64'sd2147483647;
        if (n < -128'sd2147483648) return -64'sd2147483648;
        return longint'(n);
    endfunction

    task automatic filter_reset();
        angle_noise = ANGLE_NOISE_RST;
        bias_noise  = BIAS_NOISE_RST;
        meas_noise  = MEAS_NOISE_RST;
        period      = PERIOD_RST;
        angle_est = 0; bias_est = 0; rate_est = 0;
        cov_aa = 64'sd1 << 30; cov_ab = 0; cov_ba = 0; cov_bb = 64'sd1 << 30;
    endtask

    // One predict/correct step; pushes the expected transaction.
    task automatic filter_step(t_in_item item);
        longint meas, gyro, inner, innov, s_var, k0, k1, p00, p01, p10, p11;
        logic [63:0] grow;
        t_out_item r;
        meas = longint'(item.accel_angle);
        gyro = longint'(item.gyro_dps);
        k0 = 0; k1 = 0;
        rate_est  = sat_est(gyro - bias_est);
        angle_est = sat_est(angle_est + fx_mul(rate_est, period, 32));
        p00 = cov_aa; p01 = cov_ab; p10 = cov_ba; p11 = cov_bb;
        inner = fx_mul(p11, period, 32) - p01 - p10 + (angle_noise >> 2);
        grow = (64'(bias_noise) * 64'(period)) >> 34;
        cov_aa = sat_word(p00 + fx_mul(inner, period, 32));
        cov_ab = sat_word(p01 - fx_mul(p11, period, 32));
        cov_ba = sat_word(p10 - fx_mul(p11, period, 32));
        cov_bb = sat_word(p11 + longint'(grow));
        innov = sat_est(meas - angle_est);
        s_var = cov_aa * 4 + meas_noise;
        if (s_var > 0) begin
            k0 = fx_gain(cov_aa, s_var);
            k1 = fx_gain(cov_ba, s_var);
        end
        angle_est = sat_est(angle_est + fx_mul(innov, k0, 30));
        bias_est  = sat_est(bias_est + fx_mul(innov, k1, 30));
        p00 = cov_aa; p01 = cov_ab; p10 = cov_ba; p11 = cov_bb;
        cov_aa = sat_word(p00 - fx_mul(p00, k0, 30));
        cov_ab = sat_word(p01 - fx_mul(p01, k0, 30));
        cov_ba = sat_word(p10 - fx_mul(p00, k1, 30));
        cov_bb = sat_word(p11 - fx_mul(p01, k1, 30));
        r.filtered_angle = 32'(sat_word(angle_est));
        r.unbiased_rate  = 32'(sat_word(rate_est));
        r.bias_estimate  = 32'(sat_word(bias_est));
        expected_q.push_back(r);
    endtask

    initial begin
        filter_reset();
        o_fail_count = 0;
        o_results = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            filter_reset();
            expected_q.delete();
        end else begin
            // Register writes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ANGLE_NOISE: angle_noise = i_pwdata;
                    REG_BIAS_NOISE:  bias_noise  = i_pwdata;
                    REG_MEAS_NOISE:  meas_noise  = i_pwdata;
                    REG_PERIOD:      period      = i_pwdata;
                    default: ;
                endcase
            end
            // Output transaction compared against the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $error("unexpected output transaction %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_data.filtered_angle !== want.filtered_angle) begin
                        $error("filtered_angle expected %0d actual %0d",
                               want.filtered_angle, i_out_data.filtered_angle);
                        o_fail_count++;
                    end
                    if (i_out_data.unbiased_rate !== want.unbiased_rate) begin
                        $error("unbiased_rate expected %0d actual %0d",
                               want.unbiased_rate, i_out_data.unbiased_rate);
                        o_fail_count++;
                    end
                    if (i_out_data.bias_estimate !== want.bias_estimate) begin
                        $error("bias_estimate expected %0d actual %0d",
                               want.bias_estimate, i_out_data.bias_estimate);
                        o_fail_count++;
                    end
                end
            end
            // Input transaction: predict after the compare of this edge.
            if (i_in_valid && !i_in_stall) filter_step(i_in_data);
        end
    end

endmodule

>>> tb/sv/tb_angle_bias_kalman_filter.sv
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    localparam int N_RANDOM = 1130;
    localparam int DRAIN_CYCLES = 600;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_in_item i_in_data;
    t_out_item o_out_data;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0] pwdata, prdata;
    int fail_count, pending, results;
    int sent;
    bit calm_out, hold_out;

    angle_bias_kalman_filter uut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    abkf_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit: roughly 1150 samples, with stalls.
    initial begin
        #8000000;
        $display("FAIL angle_bias_kalman_filter");
        $finish;
    end

    // Output stall: random, with a calm stretch and one long hold-off.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) i_out_stall <= 1'b1;
            else if (calm_out) i_out_stall <= 1'b0;
            else i_out_stall <= ($urandom_range(99) < 29);
        end
    end

    // One configuration write: setup phase, access phase, then idle.
    task automatic reg_write(logic [1:0] idx, logic [CFG_W-1:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every result, then let the filter settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0 || i_in_valid) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one sample; idle beforehand at random unless calm.
    task automatic send(logic signed [24:0] ang, logic signed [27:0] rate, bit calm);
        if (!calm)
            while ($urandom_range(99) < 29) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data.accel_angle <= ang;
        i_in_data.gyro_dps <= rate;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_random(bit calm);
        int kind;
        kind = $urandom_range(9);
        if (kind < 7)
            send(25'($signed($urandom_range(0, 2 * 11796480)) - 11796480),
                 28'($signed($urandom_range(0, 2 * 6553600)) - 6553600), calm);
        else
            send(25'($urandom), 28'($urandom), calm);
    endtask

    initial begin
        i_rst_n <= 1'b0; i_in_valid <= 1'b0; i_in_data <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        calm_out = 0; hold_out = 0; sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes under the reset settings.
        send(25'sd0, 28'sd0, 0);
        send(25'sd11796480, 28'sd131072000, 0);
        send(-25'sd11796480, -28'sd131072000, 0);
        send(25'h0FFFFFF, 28'h7FFFFFF, 0);
        send(25'h1000000, 28'h8000000, 0);
        send(25'h1FFFFFF, 28'hFFFFFFF, 0);
        send(25'sd65536, 28'sd655360, 0);
        drain();

        // Extreme settings: everything maximal (large growth, saturation).
        reg_write(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
        reg_write(REG_BIAS_NOISE, 32'hFFFF_FFFF);
        reg_write(REG_MEAS_NOISE, 32'hFFFF_FFFF);
        reg_write(REG_PERIOD, 32'hFFFF_FFFF);
        repeat (6) send(25'h0FFFFFF, 28'h7FFFFFF, 0);
        repeat (4) send(25'h1000000, 28'h8000000, 0);
        drain();

        // Zero noise and zero period: the innovation variance can collapse,
        // which zeroes both gains.
        reg_write(REG_ANGLE_NOISE, 32'd0);
        reg_write(REG_BIAS_NOISE, 32'd0);
        reg_write(REG_MEAS_NOISE, 32'd0);
        reg_write(REG_PERIOD, 32'd0);
        repeat (6) send(25'sd5000000, -28'sd3000000, 0);
        drain();

        // Back to the default settings for the random part.
        reg_write(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
        reg_write(REG_BIAS_NOISE, BIAS_NOISE_RST);
        reg_write(REG_MEAS_NOISE, MEAS_NOISE_RST);
        reg_write(REG_PERIOD, PERIOD_RST);

        // Random samples, with a calm stretch and one long output hold-off.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) calm_out = 1;
            if (n == 300) calm_out = 0;
            if (n == 400) begin
                hold_out = 1;
                fork
                    begin
                        repeat (3000) @(posedge i_clk);
                        hold_out = 0;
                    end
                join_none
            end
            if (n == 600) begin
                // Sender pause until all results are back, then new settings.
                drain();
                reg_write(REG_ANGLE_NOISE, $urandom);
                reg_write(REG_BIAS_NOISE, $urandom_range(0, 50000000));
                reg_write(REG_MEAS_NOISE, $urandom);
                reg_write(REG_PERIOD, $urandom_range(0, 400000000));
            end
            if (n == 900) begin
                drain();
                reg_write(REG_MEAS_NOISE, 32'd1);
                reg_write(REG_PERIOD, 32'd4294967);
            end
            send_random(n >= 200 && n < 300);
        end

        drain();
        $display("Covered %0d samples, %0d results, extreme and random settings.",
                 sent, results);
        if (fail_count == 0 && pending == 0)
            $display("PASS angle_bias_kalman_filter");
        else
            $display("FAIL angle_bias_kalman_filter");
        $finish;
    end

endmodule
